/* hw/rtl/tql_pkg.sv */
// ----------------------------------------------------------------------------
// Tabular Q-learning engine package
// Shared sizes, constants, register indexes, codes and the types that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package tql_pkg;

    // Table geometry
    localparam int NUM_STATES  = 8;
    localparam int NUM_ACTIONS = 8;
    localparam int TABLE_DEPTH = NUM_STATES * NUM_ACTIONS;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int ACT_CNT_W   = $clog2(NUM_ACTIONS + 1);

    // Field widths
    localparam int OP_W      = 1;
    localparam int STATE_W   = 3;
    localparam int ACT_W     = 3;
    localparam int REWARD_W  = 16;
    localparam int RND_W     = 32;
    localparam int VALUE_W   = 32;
    localparam int IN_DATA_W = 64;
    localparam int OUT_DATA_W = 40;

    // Configuration register widths and port sizes
    localparam int PCT_W      = 7;
    localparam int DISC_W     = 5;
    localparam int SHIFT_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EXPLORE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEARN    = 2'd2;

    // Register reset values
    localparam logic [PCT_W-1:0]   EXPLORE_RESET  = 7'd10;
    localparam logic [DISC_W-1:0]  DISCOUNT_RESET = 5'd15;
    localparam logic [SHIFT_W-1:0] LEARN_RESET    = 4'd3;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SELECT = 1'b0;
    localparam logic [OP_W-1:0] OP_UPDATE = 1'b1;

    // Percent test: x mod 100 through a reciprocal multiply, exact for 32 bits
    localparam int             PCT_RANGE = 100;
    localparam logic [RND_W-1:0] MOD_MAGIC = 32'h51EB_851F;
    localparam int             MOD_SHIFT = 37;
    localparam int             RND_PROD_W = 2 * RND_W;
    localparam int             QUOT_W     = RND_PROD_W - MOD_SHIFT;

    // Update arithmetic
    localparam int DISC_FRAC = 4;
    localparam int PROD_W    = VALUE_W + DISC_W + 1;
    localparam int CALC_W    = 40;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_MOD,
        ST_DECIDE,
        ST_SCAN,
        ST_OLD_RD,
        ST_PROD,
        ST_DIFF,
        ST_WRITE,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                 load_item;
        logic                 rnd_mul;
        logic                 rnd_mod;
        logic                 scan_issue;
        logic                 scan_take;
        logic                 scan_first;
        logic [ACT_CNT_W-1:0] scan_index;
        logic                 old_issue;
        logic                 calc_prod;
        logic                 calc_diff;
        logic                 calc_write;
        logic                 load_out;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_update;
        logic explore;
        logic row_ok;
        logic upd_ok;
    } sts_t;

endpackage

/* hw/rtl/tabular_q_learning_engine.sv */
// ----------------------------------------------------------------------------
// Tabular Q-learning engine
// An 8 by 8 table of signed 32-bit Q values with epsilon-greedy action
// selection and a saturating temporal-difference update. The engine works
// on one item at a time. A select that explores goes from the input beat
// to the result beat through the multiply, remainder, decide and finish
// states; multiply and remainder find the random word modulo one hundred.
// A greedy select reads the row from the single-read-port table one entry
// per cycle. An update scans the next-state row the same way, then reads
// the old entry and computes the multiply, the difference and the
// shift-and-saturate in turn. A new item is taken as soon as the previous
// result sits in the output register, so the next item overlaps the wait
// on the result side. The table reads as zero after reset through
// per-entry written flags; no clearing pass is needed. Configuration must
// be written only while the engine is idle; the engine does not enforce it.
// ----------------------------------------------------------------------------
module tabular_q_learning_engine (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port
    input  logic                               cfg_wen,
    input  logic [tql_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tql_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [2:0] current_state, [5:3] taken_action, [21:6] reward,
    // [24:22] next_state, [56:25] random_word, [63:57] zero
    input  logic [tql_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] operation
    input  logic [tql_pkg::OP_W-1:0]           s_axis_tuser,
    // Output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [2:0] chosen_action, [34:3] new_value, [39:35] zero
    output logic [tql_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // [0] explored
    output logic                               m_axis_tuser
);

    localparam int ST_LO  = 0;
    localparam int ACT_LO = ST_LO + tql_pkg::STATE_W;
    localparam int RWD_LO = ACT_LO + tql_pkg::ACT_W;
    localparam int NST_LO = RWD_LO + tql_pkg::REWARD_W;
    localparam int RND_LO = NST_LO + tql_pkg::STATE_W;
    localparam int VAL_LO = tql_pkg::ACT_W;
    localparam int OUT_USED = VAL_LO + tql_pkg::VALUE_W;

    tql_pkg::cmd_t cmd;
    tql_pkg::sts_t sts;
    logic [tql_pkg::ACT_W-1:0]          chosen_action;
    logic                               explored;
    logic signed [tql_pkg::VALUE_W-1:0] new_value;

    // Sequencer.
    tql_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Table, arithmetic and configuration.
    tql_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .operation     (s_axis_tuser),
        .current_state (s_axis_tdata[ST_LO +: tql_pkg::STATE_W]),
        .taken_action  (s_axis_tdata[ACT_LO +: tql_pkg::ACT_W]),
        .reward        ($signed(s_axis_tdata[RWD_LO +: tql_pkg::REWARD_W])),
        .next_state    (s_axis_tdata[NST_LO +: tql_pkg::STATE_W]),
        .random_word   (s_axis_tdata[RND_LO +: tql_pkg::RND_W]),
        .cmd           (cmd),
        .sts           (sts),
        .chosen_action (chosen_action),
        .explored      (explored),
        .new_value     (new_value)
    );

    // Pack the result beat.
    assign m_axis_tdata = {{(tql_pkg::OUT_DATA_W - OUT_USED){1'b0}}, new_value, chosen_action};
    assign m_axis_tuser = explored;

    // An accepted item blocks the input until its work is done.
    a_single_item: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready
    ) else $error("input accepted while an item is in progress");

    // A result is loaded only into a free or draining output register.
    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_axis_tvalid || m_axis_tready)
    ) else $error("pending result overwritten");

    // The table is written only by update items.
    a_write_on_update: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.calc_write |-> (sts.is_update && sts.upd_ok)
    ) else $error("table written outside a valid update");

    // An explored choice carries a zero value.
    a_explore_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[34:3] == '0)
    ) else $error("explored result with nonzero value");

endmodule

/* hw/rtl/tql_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module tql_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/tql_ctrl.sv */
// ----------------------------------------------------------------------------
// Tabular Q-learning controller
// Sequences one item at a time through the percent test, the row scan and
// the update arithmetic, and owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module tql_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  tql_pkg::sts_t sts,
    output tql_pkg::cmd_t cmd
);

    tql_pkg::state_t state_reg;
    tql_pkg::state_t state_next;
    logic [tql_pkg::ACT_CNT_W-1:0] scan_cnt_reg;
    logic [tql_pkg::ACT_CNT_W-1:0] scan_cnt_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic scan_done;
    logic out_free;

    assign scan_done = (scan_cnt_reg == tql_pkg::ACT_CNT_W'(tql_pkg::NUM_ACTIONS));
    assign out_free  = !out_valid_reg || out_ready;

    // State, scan counter and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tql_pkg::ST_IDLE;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tql_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tql_pkg::ST_MUL;
                end
            end
            tql_pkg::ST_MUL:
            begin
                state_next = tql_pkg::ST_MOD;
            end
            tql_pkg::ST_MOD:
            begin
                state_next = tql_pkg::ST_DECIDE;
            end
            tql_pkg::ST_DECIDE:
            begin
                if (sts.is_update)
                begin
                    state_next = sts.upd_ok ? tql_pkg::ST_SCAN : tql_pkg::ST_FINISH;
                end
                else if (!sts.explore && sts.row_ok)
                begin
                    state_next = tql_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = tql_pkg::ST_FINISH;
                end
            end
            tql_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = sts.is_update ? tql_pkg::ST_OLD_RD : tql_pkg::ST_FINISH;
                end
            end
            tql_pkg::ST_OLD_RD:
            begin
                state_next = tql_pkg::ST_PROD;
            end
            tql_pkg::ST_PROD:
            begin
                state_next = tql_pkg::ST_DIFF;
            end
            tql_pkg::ST_DIFF:
            begin
                state_next = tql_pkg::ST_WRITE;
            end
            tql_pkg::ST_WRITE:
            begin
                state_next = tql_pkg::ST_FINISH;
            end
            tql_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = tql_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tql_pkg::ST_IDLE;
            end
        endcase
    end

    // Scan counter: cleared before the scan, one step per cycle during it.
    always_comb
    begin
        scan_cnt_next = scan_cnt_reg;
        if (state_reg == tql_pkg::ST_DECIDE)
        begin
            scan_cnt_next = '0;
        end
        else if (state_reg == tql_pkg::ST_SCAN && !scan_done)
        begin
            scan_cnt_next = scan_cnt_reg + tql_pkg::ACT_CNT_W'(1);
        end
    end

    // Commands and handshake outputs.
    always_comb
    begin
        cmd            = '0;
        cmd.scan_index = scan_cnt_reg;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            tql_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            tql_pkg::ST_MUL:
            begin
                cmd.rnd_mul = 1'b1;
            end
            tql_pkg::ST_MOD:
            begin
                cmd.rnd_mod = 1'b1;
            end
            tql_pkg::ST_SCAN:
            begin
                cmd.scan_issue = !scan_done;
                cmd.scan_take  = (scan_cnt_reg != '0);
                cmd.scan_first = (scan_cnt_reg == tql_pkg::ACT_CNT_W'(1));
            end
            tql_pkg::ST_OLD_RD:
            begin
                cmd.old_issue = 1'b1;
            end
            tql_pkg::ST_PROD:
            begin
                cmd.calc_prod = 1'b1;
            end
            tql_pkg::ST_DIFF:
            begin
                cmd.calc_diff = 1'b1;
            end
            tql_pkg::ST_WRITE:
            begin
                cmd.calc_write = 1'b1;
            end
            tql_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

/* hw/rtl/tql_datapath.sv */
// ----------------------------------------------------------------------------
// Tabular Q-learning datapath
// Holds the configuration registers, the item registers, the Q table with
// its written-entry flags, the percent test, the row maximum and the update
// arithmetic, and the output payload register.
// ----------------------------------------------------------------------------
module tql_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wen,
    input  logic [tql_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tql_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic [tql_pkg::OP_W-1:0]            operation,
    input  logic [tql_pkg::STATE_W-1:0]         current_state,
    input  logic [tql_pkg::ACT_W-1:0]           taken_action,
    input  logic signed [tql_pkg::REWARD_W-1:0] reward,
    input  logic [tql_pkg::STATE_W-1:0]         next_state,
    input  logic [tql_pkg::RND_W-1:0]           random_word,
    input  tql_pkg::cmd_t                       cmd,
    output tql_pkg::sts_t                       sts,
    output logic [tql_pkg::ACT_W-1:0]           chosen_action,
    output logic                                explored,
    output logic signed [tql_pkg::VALUE_W-1:0]  new_value
);

    // Configuration registers
    logic [tql_pkg::PCT_W-1:0]   explore_reg;
    logic [tql_pkg::DISC_W-1:0]  discount_reg;
    logic [tql_pkg::SHIFT_W-1:0] learn_reg;

    // Item registers
    logic [tql_pkg::OP_W-1:0]            op_reg;
    logic [tql_pkg::STATE_W-1:0]         st_reg;
    logic [tql_pkg::ACT_W-1:0]           act_reg;
    logic signed [tql_pkg::REWARD_W-1:0] reward_reg;
    logic [tql_pkg::STATE_W-1:0]         nst_reg;
    logic [tql_pkg::RND_W-1:0]           rnd_reg;

    // Percent test
    logic [tql_pkg::RND_PROD_W-1:0] rnd_prod_reg;
    logic [tql_pkg::QUOT_W-1:0]     quot;
    logic [tql_pkg::PCT_W-1:0]      rem_reg;

    // Table access
    logic [tql_pkg::TABLE_DEPTH-1:0] valid_reg;
    logic [tql_pkg::ADDR_W-1:0]      raddr;
    logic [tql_pkg::ADDR_W-1:0]      upd_addr;
    logic [tql_pkg::STATE_W-1:0]     scan_row;
    logic                            rd_live_reg;
    logic [tql_pkg::VALUE_W-1:0]     ram_rdata;
    logic signed [tql_pkg::VALUE_W-1:0] rd_data;

    // Row maximum
    logic signed [tql_pkg::VALUE_W-1:0] best_reg;
    logic [tql_pkg::ACT_W-1:0]          best_idx_reg;

    // Update arithmetic
    logic signed [tql_pkg::VALUE_W-1:0] old_reg;
    logic signed [tql_pkg::PROD_W-1:0]  prod_next;
    logic signed [tql_pkg::PROD_W-1:0]  prod_reg;
    logic signed [tql_pkg::PROD_W-1:0]  prod_sh;
    logic signed [tql_pkg::CALC_W-1:0]  target;
    logic signed [tql_pkg::CALC_W-1:0]  diff_reg;
    logic signed [tql_pkg::CALC_W-1:0]  step;
    logic signed [tql_pkg::CALC_W-1:0]  nv_wide;
    logic signed [tql_pkg::CALC_W-1:0]  sat_hi;
    logic signed [tql_pkg::CALC_W-1:0]  sat_lo;
    logic signed [tql_pkg::VALUE_W-1:0] nv_sat;
    logic signed [tql_pkg::VALUE_W-1:0] nv_reg;

    // Output payload
    logic [tql_pkg::ACT_W-1:0]          res_action;
    logic                               res_explored;
    logic signed [tql_pkg::VALUE_W-1:0] res_value;
    logic [tql_pkg::ACT_W-1:0]          out_action_reg;
    logic                               out_explored_reg;
    logic signed [tql_pkg::VALUE_W-1:0] out_value_reg;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            explore_reg  <= tql_pkg::EXPLORE_RESET;
            discount_reg <= tql_pkg::DISCOUNT_RESET;
            learn_reg    <= tql_pkg::LEARN_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                tql_pkg::REG_EXPLORE:  explore_reg  <= cfg_wdata[tql_pkg::PCT_W-1:0];
                tql_pkg::REG_DISCOUNT: discount_reg <= cfg_wdata[tql_pkg::DISC_W-1:0];
                tql_pkg::REG_LEARN:    learn_reg    <= cfg_wdata[tql_pkg::SHIFT_W-1:0];
                default:               ;
            endcase
        end
    end

    // Item capture on the input beat.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg     <= operation;
            st_reg     <= current_state;
            act_reg    <= taken_action;
            reward_reg <= reward;
            nst_reg    <= next_state;
            rnd_reg    <= random_word;
        end
    end

    // Remainder of the random word by one hundred: reciprocal product first,
    // then one multiply by the constant and a subtract.
    assign quot = rnd_prod_reg[tql_pkg::RND_PROD_W-1:tql_pkg::MOD_SHIFT];

    always_ff @(posedge clk)
    begin
        if (cmd.rnd_mul)
        begin
            rnd_prod_reg <= tql_pkg::RND_PROD_W'(rnd_reg)
                          * tql_pkg::RND_PROD_W'(tql_pkg::MOD_MAGIC);
        end
        if (cmd.rnd_mod)
        begin
            rem_reg <= tql_pkg::PCT_W'(rnd_reg - tql_pkg::RND_W'(quot)
                                       * tql_pkg::RND_W'(tql_pkg::PCT_RANGE));
        end
    end

    // Status for the controller.
    always_comb
    begin
        sts.is_update = (op_reg == tql_pkg::OP_UPDATE);
        sts.explore   = (rem_reg < explore_reg);
        sts.row_ok    = (32'(st_reg) < 32'(tql_pkg::NUM_STATES));
        sts.upd_ok    = sts.row_ok
                     && (32'(nst_reg) < 32'(tql_pkg::NUM_STATES))
                     && (32'(act_reg) < 32'(tql_pkg::NUM_ACTIONS));
    end

    // Read address: the scanned row, or the entry being updated.
    assign scan_row = sts.is_update ? nst_reg : st_reg;
    assign upd_addr = tql_pkg::ADDR_W'(st_reg) * tql_pkg::ADDR_W'(tql_pkg::NUM_ACTIONS)
                    + tql_pkg::ADDR_W'(act_reg);

    always_comb
    begin
        if (cmd.old_issue)
        begin
            raddr = upd_addr;
        end
        else
        begin
            raddr = tql_pkg::ADDR_W'(scan_row) * tql_pkg::ADDR_W'(tql_pkg::NUM_ACTIONS)
                  + tql_pkg::ADDR_W'(cmd.scan_index);
        end
    end

    // Q table storage.
    tql_ram #(
        .WIDTH (tql_pkg::VALUE_W),
        .DEPTH (tql_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (cmd.calc_write),
        .waddr (upd_addr),
        .wdata (nv_sat),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // Written-entry flags: an entry never written reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rd_live_reg <= 1'b0;
        end
        else
        begin
            rd_live_reg <= valid_reg[raddr];
            if (cmd.calc_write)
            begin
                valid_reg[upd_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_live_reg ? $signed(ram_rdata) : '0;

    // Running row maximum; a later entry wins only when strictly greater.
    always_ff @(posedge clk)
    begin
        if (cmd.scan_take && (cmd.scan_first || rd_data > best_reg))
        begin
            best_reg     <= rd_data;
            best_idx_reg <= tql_pkg::ACT_W'(cmd.scan_index - tql_pkg::ACT_CNT_W'(1));
        end
    end

    // Update arithmetic, one step per cycle.
    assign prod_next = best_reg * $signed({1'b0, discount_reg});
    assign prod_sh   = prod_reg >>> tql_pkg::DISC_FRAC;
    assign target    = {{(tql_pkg::CALC_W - tql_pkg::REWARD_W){reward_reg[tql_pkg::REWARD_W-1]}},
                        reward_reg}
                     + {{(tql_pkg::CALC_W - tql_pkg::PROD_W){prod_sh[tql_pkg::PROD_W-1]}},
                        prod_sh};
    assign step      = diff_reg >>> learn_reg;
    assign nv_wide   = {{(tql_pkg::CALC_W - tql_pkg::VALUE_W){old_reg[tql_pkg::VALUE_W-1]}},
                        old_reg} + step;
    assign sat_hi    = {{(tql_pkg::CALC_W - tql_pkg::VALUE_W + 1){1'b0}},
                        {(tql_pkg::VALUE_W - 1){1'b1}}};
    assign sat_lo    = {{(tql_pkg::CALC_W - tql_pkg::VALUE_W + 1){1'b1}},
                        {(tql_pkg::VALUE_W - 1){1'b0}}};

    // Saturate the new value to the signed 32-bit range.
    always_comb
    begin
        if (nv_wide > sat_hi)
        begin
            nv_sat = sat_hi[tql_pkg::VALUE_W-1:0];
        end
        else if (nv_wide < sat_lo)
        begin
            nv_sat = sat_lo[tql_pkg::VALUE_W-1:0];
        end
        else
        begin
            nv_sat = nv_wide[tql_pkg::VALUE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc_prod)
        begin
            old_reg  <= rd_data;
            prod_reg <= prod_next;
        end
        if (cmd.calc_diff)
        begin
            diff_reg <= target - {{(tql_pkg::CALC_W - tql_pkg::VALUE_W){old_reg[tql_pkg::VALUE_W-1]}},
                                  old_reg};
        end
        if (cmd.calc_write)
        begin
            nv_reg <= nv_sat;
        end
    end

    // Result fields for the finished item.
    always_comb
    begin
        res_action   = '0;
        res_explored = 1'b0;
        res_value    = '0;
        if (sts.is_update)
        begin
            res_action = act_reg;
            if (sts.upd_ok)
            begin
                res_value = nv_reg;
            end
        end
        else if (sts.explore)
        begin
            res_action   = tql_pkg::ACT_W'(rnd_reg % tql_pkg::RND_W'(tql_pkg::NUM_ACTIONS));
            res_explored = 1'b1;
        end
        else if (sts.row_ok)
        begin
            res_action = best_idx_reg;
            res_value  = best_reg;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_action_reg   <= res_action;
            out_explored_reg <= res_explored;
            out_value_reg    <= res_value;
        end
    end

    assign chosen_action = out_action_reg;
    assign explored      = out_explored_reg;
    assign new_value     = out_value_reg;

endmodule

/* tb/sv/tb_tabular_q_learning_engine.sv */
// ----------------------------------------------------------------------------
// Tabular Q-learning engine testbench
// Sends select and update beats into the engine and keeps a local copy of
// the Q table and of the three registers. Every result beat is checked
// field by field against the oldest predicted result. A directed table
// runs first. Random phases follow under changing register settings; two
// of them drive one row to the positive and the negative saturation limit.
// ----------------------------------------------------------------------------
module tb_tabular_q_learning_engine;
    import tql_pkg::*;

    localparam int     CLK_HALF     = 10;
    localparam int     CYCLE_LIMIT  = 500000;
    localparam int     DRAIN_CYCLES = 24;
    localparam int     LONG_HOLD    = 400;
    localparam int     HOLD_AT      = 250;
    localparam int     CLIMB_ROW    = 6;
    localparam int     SINK_ROW     = 5;
    localparam longint VAL_MAX      = 64'sd2147483647;
    localparam longint VAL_MIN      = -VAL_MAX - 1;

    // One input beat, split into its fields
    typedef struct packed {
        logic [OP_W-1:0]            op;
        logic [STATE_W-1:0]         cur;
        logic [ACT_W-1:0]           act;
        logic signed [REWARD_W-1:0] reward;
        logic [STATE_W-1:0]         nxt;
        logic [RND_W-1:0]           rnd;
    } q_item_t;

    // One result beat, split into its fields
    typedef struct packed {
        logic [ACT_W-1:0]          act;
        logic                      explored;
        logic signed [VALUE_W-1:0] value;
    } q_result_t;

    typedef struct packed {
        q_item_t   item;
        bit        typed;
        q_result_t want;
    } plan_row_t;

    typedef enum logic [1:0] {
        MODE_MIX,
        MODE_CLIMB,
        MODE_SINK
    } fill_mode_e;

    typedef struct packed {
        bit         rand_cfg;
        int         pct;
        int         disc;
        int         shift;
        fill_mode_e mode;
        int         count;
        int         idle;
    } phase_t;

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  cfg_wen       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [OP_W-1:0]       s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    // Local copy of the engine state
    logic signed [VALUE_W-1:0] q_table [TABLE_DEPTH];
    int                        pct_reg;
    int                        disc_reg;
    int                        shift_reg;

    q_result_t due_results [$];
    int        n_errors     = 0;
    int        results_seen = 0;
    int        send_idle    = 30;

    // Directed beats under the reset settings; typed rows hold results that
    // follow from an all-zero table, the rest go through the local copy.
    plan_row_t plan [17] = '{
        // Explore with a zero random word
        '{'{OP_SELECT, 3'd0, 3'd0, 16'sd0, 3'd0, 32'd0}, 1'b1, '{3'd0, 1'b1, 32'sd0}},
        // Greedy on a zero row, random word well above the explore band
        '{'{OP_SELECT, 3'd7, 3'd7, 16'sd0, 3'd7, 32'd99}, 1'b1, '{3'd0, 1'b0, 32'sd0}},
        // All-ones random word leaves a remainder of 95
        '{'{OP_SELECT, 3'd3, 3'd0, 16'sd0, 3'd0, 32'hFFFF_FFFF}, 1'b1,
          '{3'd0, 1'b0, 32'sd0}},
        // 109 explores and picks action 5
        '{'{OP_SELECT, 3'd5, 3'd0, 16'sd0, 3'd0, 32'd109}, 1'b1, '{3'd5, 1'b1, 32'sd0}},
        // Remainder equal to the percentage does not explore
        '{'{OP_SELECT, 3'd1, 3'd0, 16'sd0, 3'd0, 32'd10}, 1'b1, '{3'd0, 1'b0, 32'sd0}},
        // Largest and smallest rewards on a zero table
        '{'{OP_UPDATE, 3'd0, 3'd7, 16'sh7FFF, 3'd0, 32'd0}, 1'b1,
          '{3'd7, 1'b0, 32'sd4095}},
        '{'{OP_UPDATE, 3'd0, 3'd0, 16'sh8000, 3'd7, 32'd0}, 1'b1,
          '{3'd0, 1'b0, -32'sd4096}},
        '{'{OP_SELECT, 3'd0, 3'd0, 16'sd0, 3'd0, 32'd50}, 1'b0, '0},
        // Negative error rounds toward minus infinity
        '{'{OP_UPDATE, 3'd3, 3'd0, -16'sd1, 3'd3, 32'd0}, 1'b1, '{3'd0, 1'b0, -32'sd1}},
        // Two equal entries: the lower action wins the tie
        '{'{OP_UPDATE, 3'd2, 3'd4, 16'sd800, 3'd6, 32'd0}, 1'b0, '0},
        '{'{OP_UPDATE, 3'd2, 3'd6, 16'sd800, 3'd6, 32'd0}, 1'b0, '0},
        '{'{OP_SELECT, 3'd2, 3'd0, 16'sd0, 3'd0, 32'd99}, 1'b0, '0},
        '{'{OP_UPDATE, 3'd1, 3'd3, 16'sd12345, 3'd0, 32'h5555_5555}, 1'b0, '0},
        '{'{OP_UPDATE, 3'd0, 3'd7, 16'sh7FFF, 3'd0, 32'hFFFF_FFFF}, 1'b0, '0},
        '{'{OP_SELECT, 3'd3, 3'd0, 16'sd0, 3'd0, 32'd99}, 1'b0, '0},
        '{'{OP_UPDATE, 3'd7, 3'd7, 16'sh5555, 3'd7, 32'hAAAA_AAAA}, 1'b0, '0},
        '{'{OP_SELECT, 3'd6, 3'd0, 16'shAAAA, 3'd0, 32'hAAAA_AAAA}, 1'b0, '0}
    };

    // Random phases: settings, kind of traffic, beat count, sender idle percent
    phase_t phases [11] = '{
        '{1'b0, 0, 16, 1, MODE_MIX, 100, 0},
        '{1'b0, 127, 31, 0, MODE_MIX, 50, 20},
        '{1'b0, 100, 0, 0, MODE_CLIMB, 16, 50},
        '{1'b0, 100, 31, 0, MODE_CLIMB, 220, 0},
        '{1'b0, 50, 0, 15, MODE_MIX, 60, 20},
        '{1'b0, 0, 0, 0, MODE_SINK, 16, 50},
        '{1'b0, 101, 31, 0, MODE_SINK, 220, 0},
        '{1'b1, 0, 0, 0, MODE_MIX, 70, 20},
        '{1'b1, 0, 0, 0, MODE_MIX, 70, 50},
        '{1'b1, 0, 0, 0, MODE_MIX, 70, 0},
        '{1'b0, 1, 8, 4, MODE_MIX, 60, 20}
    };

    tabular_q_learning_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Largest entry of a row; the lowest action wins a tie.
    function automatic logic signed [VALUE_W-1:0] row_peak(input logic [STATE_W-1:0] row,
                                                           output logic [ACT_W-1:0] at);
        logic signed [VALUE_W-1:0] peak;
        peak = q_table[{row, 3'd0}];
        at   = '0;
        for (int a = 1; a < NUM_ACTIONS; a++)
        begin
            if (q_table[{row, a[ACT_W-1:0]}] > peak)
            begin
                peak = q_table[{row, a[ACT_W-1:0]}];
                at   = a[ACT_W-1:0];
            end
        end
        return peak;
    endfunction

    // Result of one beat; an update also writes the local table. With eight
    // rows and eight actions every field value is a valid index.
    function automatic q_result_t q_step(input q_item_t it);
        q_result_t        res;
        logic [ACT_W-1:0] at;
        longint           peak;
        longint           old;
        longint           gain;
        longint           target;
        longint           next_val;
        res = '0;
        if (it.op == OP_SELECT)
        begin
            if ((it.rnd % PCT_RANGE) < pct_reg)
            begin
                res.act      = it.rnd % NUM_ACTIONS;
                res.explored = 1'b1;
            end
            else
            begin
                res.value = row_peak(it.cur, at);
                res.act   = at;
            end
        end
        else
        begin
            res.act  = it.act;
            peak     = row_peak(it.nxt, at);
            old      = q_table[{it.cur, it.act}];
            gain     = $signed(it.reward);
            target   = gain + ((peak * disc_reg) >>> DISC_FRAC);
            next_val = old + ((target - old) >>> shift_reg);
            if (next_val > VAL_MAX)
                next_val = VAL_MAX;
            if (next_val < VAL_MIN)
                next_val = VAL_MIN;
            q_table[{it.cur, it.act}] = next_val[VALUE_W-1:0];
            res.value = next_val[VALUE_W-1:0];
        end
        return res;
    endfunction

    // Idle length: zero unless a roll falls under the idle percent; then mostly short, now and then long.
    function automatic int pick_gap(input int idle_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll >= idle_pct)
            return 0;
        if ($urandom_range(0, 9) != 0)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Random beat; climb and sink traffic hammers one row with same-sign
    // rewards so that its values run away, starting with a pass over all
    // actions.
    function automatic q_item_t make_item(input fill_mode_e mode, input int k);
        q_item_t it;
        it.rnd    = $urandom;
        it.reward = $urandom;
        it.cur    = $urandom_range(0, NUM_STATES - 1);
        it.act    = $urandom_range(0, NUM_ACTIONS - 1);
        it.nxt    = $urandom_range(0, NUM_STATES - 1);
        it.op     = $urandom_range(0, 1) ? OP_UPDATE : OP_SELECT;
        if (mode != MODE_MIX)
        begin
            it.op  = (k >= NUM_ACTIONS && $urandom_range(0, 9) == 0) ? OP_SELECT : OP_UPDATE;
            it.act = k % NUM_ACTIONS;
            if (mode == MODE_CLIMB)
            begin
                it.cur    = CLIMB_ROW;
                it.reward = $urandom_range(16000, 32767);
            end
            else
            begin
                it.cur    = SINK_ROW;
                it.reward = -$urandom_range(16000, 32768);
            end
            it.nxt = it.cur;
        end
        return it;
    endfunction

    // Offer one beat after a random gap and hold it until it is taken.
    task automatic offer_item(input q_item_t it, input bit typed, input q_result_t want);
        int        gap;
        q_result_t got;
        gap = pick_gap(send_idle);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({it.rnd, it.nxt, it.reward, it.act, it.cur});
        s_axis_tuser  <= it.op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        got = q_step(it);
        due_results.push_back(typed ? want : got);
    endtask

    // Stop sending, let every result come back, then write all registers.
    task automatic retune(input int pct, input int disc, input int shift);
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= REG_EXPLORE;
        cfg_wdata <= CFG_DATA_W'(pct);
        @(posedge clk);
        cfg_index <= REG_DISCOUNT;
        cfg_wdata <= CFG_DATA_W'(disc);
        @(posedge clk);
        cfg_index <= REG_LEARN;
        cfg_wdata <= CFG_DATA_W'(shift);
        @(posedge clk);
        cfg_wen   <= 1'b0;
        pct_reg   = pct;
        disc_reg  = disc;
        shift_reg = shift;
    endtask

    // Sender: reset, directed table, then the random phases.
    initial
    begin : stimulus
        q_item_t   it;
        q_result_t none;
        phase_t    ph;
        none      = '0;
        pct_reg   = EXPLORE_RESET;
        disc_reg  = DISCOUNT_RESET;
        shift_reg = LEARN_RESET;
        for (int i = 0; i < TABLE_DEPTH; i++)
            q_table[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            offer_item(plan[i].item, plan[i].typed, plan[i].want);

        foreach (phases[p])
        begin
            ph = phases[p];
            if (ph.rand_cfg)
            begin
                ph.pct   = $urandom_range(0, 127);
                ph.disc  = $urandom_range(0, 31);
                ph.shift = $urandom_range(0, 15);
            end
            retune(ph.pct, ph.disc, ph.shift);
            send_idle = ph.idle;
            for (int k = 0; k < ph.count; k++)
            begin
                it = make_item(ph.mode, k);
                offer_item(it, 1'b0, none);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Receiver: check each result beat and stall at random, with one long
    // hold-off so that the engine backs up into its input.
    initial
    begin : result_sink
        int        hold;
        int        window;
        int        idle_pct;
        bit        long_hold_done;
        q_result_t want;
        hold           = 0;
        window         = 0;
        idle_pct       = 0;
        long_hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (due_results.size() == 0)
                begin
                    $error("result beat with no result due: data %h explored %b",
                           m_axis_tdata, m_axis_tuser);
                    n_errors++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (m_axis_tdata[ACT_W-1:0] !== want.act)
                    begin
                        $error("chosen_action: expected %0d, actual %0d",
                               want.act, m_axis_tdata[ACT_W-1:0]);
                        n_errors++;
                    end
                    if (m_axis_tuser !== want.explored)
                    begin
                        $error("explored: expected %0d, actual %0d",
                               want.explored, m_axis_tuser);
                        n_errors++;
                    end
                    if (m_axis_tdata[ACT_W +: VALUE_W] !== want.value)
                    begin
                        $error("new_value: expected %0d, actual %0d",
                               want.value, $signed(m_axis_tdata[ACT_W +: VALUE_W]));
                        n_errors++;
                    end
                end
            end

            // Change how often the receiver stalls at the end of each window.
            if (window == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 25;
                    default: idle_pct = 60;
                endcase
                window = 256;
            end
            window--;

            if (!long_hold_done && results_seen >= HOLD_AT)
            begin
                hold           = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                hold--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                hold = pick_gap(idle_pct);
            end
        end
    end

    // Cycle limit: several times the slowest correct run.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/tql_pkg.sv
hw/rtl/tql_ram.sv
hw/rtl/tql_ctrl.sv
hw/rtl/tql_datapath.sv
hw/rtl/tabular_q_learning_engine.sv
tb/sv/tb_tabular_q_learning_engine.sv
